// ===== src/mar_pkg.sv =====
// Shared types, constants and sine table generation for the axis rotation block.
package mar_pkg;

   localparam int ENTRY_WIDTH        = 32;
   localparam int ANGLE_FIELD_WIDTH  = 12;
   localparam int ANGLE_BITS_DEFAULT = 12;
   localparam int TRIG_FRAC          = 14;
   localparam int TRIG_MAG_WIDTH     = 15;   // 0 .. 16384
   localparam int TRIG_WIDTH         = 16;   // signed -16384 .. 16384
   localparam int FIX_FRAC           = 60;
   localparam logic [63:0] HALF_PI_FIX = 64'h1921FB54442D1847;

   typedef enum logic {
      AXIS_X = 1'b0,
      AXIS_Y = 1'b1
   } axis_type;

   typedef struct packed {
      logic                           action;
      logic [ANGLE_FIELD_WIDTH-1:0]   angle;
      logic signed [ENTRY_WIDTH-1:0]  in_c0_r0;
      logic signed [ENTRY_WIDTH-1:0]  in_c0_r1;
      logic signed [ENTRY_WIDTH-1:0]  in_c0_r2;
      logic signed [ENTRY_WIDTH-1:0]  in_c1_r0;
      logic signed [ENTRY_WIDTH-1:0]  in_c1_r1;
      logic signed [ENTRY_WIDTH-1:0]  in_c1_r2;
      logic signed [ENTRY_WIDTH-1:0]  in_c2_r0;
      logic signed [ENTRY_WIDTH-1:0]  in_c2_r1;
      logic signed [ENTRY_WIDTH-1:0]  in_c2_r2;
   } req_payload_type;

   typedef struct packed {
      logic signed [ENTRY_WIDTH-1:0]  out_c0_r0;
      logic signed [ENTRY_WIDTH-1:0]  out_c0_r1;
      logic signed [ENTRY_WIDTH-1:0]  out_c0_r2;
      logic signed [ENTRY_WIDTH-1:0]  out_c1_r0;
      logic signed [ENTRY_WIDTH-1:0]  out_c1_r1;
      logic signed [ENTRY_WIDTH-1:0]  out_c1_r2;
      logic signed [ENTRY_WIDTH-1:0]  out_c2_r0;
      logic signed [ENTRY_WIDTH-1:0]  out_c2_r1;
      logic signed [ENTRY_WIDTH-1:0]  out_c2_r2;
   } rsp_payload_type;

   // (a*b) >> 60 with the partial products truncated separately
   function automatic logic [63:0] fix_mul(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] ah, al, bh, bl, hh, mid, ll;
      ah  = a >> 32;
      al  = {32'd0, a[31:0]};
      bh  = b >> 32;
      bl  = {32'd0, b[31:0]};
      hh  = ah * bh;
      mid = ah * bl + al * bh;
      ll  = al * bl;
      return (hh << (64 - FIX_FRAC)) + (mid >> (FIX_FRAC - 32)) + (ll >> FIX_FRAC);
   endfunction

   // term divided by (2i)(2i+1) of the Taylor series
   function automatic logic [63:0] taylor_div(input logic [63:0] t, input int i);
      logic [63:0] q;
      unique case (i)
         1:       q = t / 64'd6;
         2:       q = t / 64'd20;
         3:       q = t / 64'd42;
         4:       q = t / 64'd72;
         5:       q = t / 64'd110;
         6:       q = t / 64'd156;
         7:       q = t / 64'd210;
         8:       q = t / 64'd272;
         9:       q = t / 64'd342;
         10:      q = t / 64'd420;
         11:      q = t / 64'd506;
         12:      q = t / 64'd600;
         13:      q = t / 64'd702;
         default: q = t;
      endcase
      return q;
   endfunction

   function automatic logic [63:0] fix_sin(input logic [63:0] x);
      logic [63:0] x2, term, sum;
      x2   = fix_mul(x, x);
      term = x;
      sum  = x;
      for (int i = 1; i <= 13; i++) begin
         term = taylor_div(fix_mul(term, x2), i);
         if ((i % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   // quarter-wave entry k as Q1.14, rounded to nearest
   function automatic logic [TRIG_MAG_WIDTH-1:0] quarter_entry(input int k, input int quad_bits);
      logic [63:0] x, s, r;
      x = fix_mul(HALF_PI_FIX, 64'(k) << (FIX_FRAC - quad_bits));
      s = fix_sin(x);
      r = (s + (64'd1 << (FIX_FRAC - TRIG_FRAC - 1))) >> (FIX_FRAC - TRIG_FRAC);
      return r[TRIG_MAG_WIDTH-1:0];
   endfunction

endpackage

// ===== src/mar_ram.sv =====
// Generic RAM, one write port and two registered read ports.
module mar_ram import mar_pkg::*; #(
   parameter int WIDTH = TRIG_MAG_WIDTH,
   parameter int DEPTH = (1 << (ANGLE_BITS_DEFAULT - 2)) + 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== src/mar_table_fill.sv =====
// Sweeps the quarter-wave sine table into the RAM after reset, one entry a cycle.
module mar_table_fill import mar_pkg::*; #(
   parameter int QUAD_BITS = ANGLE_BITS_DEFAULT - 2
) (
   input  logic                      clock,
   input  logic                      reset,
   output logic                      wr_en,
   output logic [QUAD_BITS:0]        wr_addr,
   output logic [TRIG_MAG_WIDTH-1:0] wr_data,
   output logic                      done
);

   localparam int DEPTH = (1 << QUAD_BITS) + 1;
   localparam logic [QUAD_BITS:0] LAST_ADDR = (QUAD_BITS + 1)'(DEPTH - 1);

   logic [TRIG_MAG_WIDTH-1:0] rom_vals [DEPTH];

   for (genvar k = 0; k < DEPTH; k++) begin : g_rom
      localparam logic [TRIG_MAG_WIDTH-1:0] VAL = quarter_entry(k, QUAD_BITS);
      assign rom_vals[k] = VAL;
   end

   logic                      busy_ff, busy_in;
   logic [QUAD_BITS:0]        cnt_ff, cnt_in;
   logic                      wr_en_ff;
   logic [QUAD_BITS:0]        wr_addr_ff;
   logic [TRIG_MAG_WIDTH-1:0] wr_data_ff;
   logic                      done_ff, done_in;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_ADDR) begin
            busy_in = 1'b0;
         end
      end
      done_in = done_ff || (wr_en_ff && (wr_addr_ff == LAST_ADDR));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         cnt_ff   <= '0;
         wr_en_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         cnt_ff   <= cnt_in;
         wr_en_ff <= busy_ff;
         done_ff  <= done_in;
      end
      wr_addr_ff <= cnt_ff;
      wr_data_ff <= rom_vals[cnt_ff];
   end

   assign wr_en   = wr_en_ff;
   assign wr_addr = wr_addr_ff;
   assign wr_data = wr_data_ff;
   assign done    = done_ff;

endmodule

// ===== src/mar_lane.sv =====
// One column's rotated pair: a' = c*p - s*q, b' = s*p + c*q, scaled and saturated.
module mar_lane import mar_pkg::*; (
   input  logic signed [ENTRY_WIDTH-1:0] p,
   input  logic signed [ENTRY_WIDTH-1:0] q,
   input  logic signed [TRIG_WIDTH-1:0]  cos_val,
   input  logic signed [TRIG_WIDTH-1:0]  sin_val,
   output logic signed [ENTRY_WIDTH-1:0] out_a,
   output logic signed [ENTRY_WIDTH-1:0] out_b
);

   localparam int PW  = ENTRY_WIDTH + TRIG_WIDTH;
   localparam int SW  = PW + 1;
   localparam int SHW = SW - TRIG_FRAC;   // ENTRY_WIDTH + 3

   function automatic logic signed [ENTRY_WIDTH-1:0] sat(input logic signed [SHW-1:0] v);
      logic [SHW-ENTRY_WIDTH:0] top;
      logic signed [ENTRY_WIDTH-1:0] r;
      top = v[SHW-1:ENTRY_WIDTH-1];
      if ((top == '0) || (top == '1)) begin
         r = v[ENTRY_WIDTH-1:0];
      end else if (v[SHW-1]) begin
         r = {1'b1, {(ENTRY_WIDTH-1){1'b0}}};
      end else begin
         r = {1'b0, {(ENTRY_WIDTH-1){1'b1}}};
      end
      return r;
   endfunction

   logic signed [PW-1:0]  cp, sq, sp, cq;
   logic signed [SW-1:0]  sum_a, sum_b;
   logic signed [SHW-1:0] sh_a, sh_b;

   assign cp = PW'(p) * PW'(cos_val);
   assign sq = PW'(q) * PW'(sin_val);
   assign sp = PW'(p) * PW'(sin_val);
   assign cq = PW'(q) * PW'(cos_val);

   assign sum_a = SW'(cp) - SW'(sq);
   assign sum_b = SW'(sp) + SW'(cq);

   // arithmetic shift floors, as wanted
   assign sh_a = SHW'(sum_a >>> TRIG_FRAC);
   assign sh_b = SHW'(sum_b >>> TRIG_FRAC);

   assign out_a = sat(sh_a);
   assign out_b = sat(sh_b);

endmodule

// ===== src/matrix_axis_rotation.sv =====
// Rotation of a 3x3 transform block about the X or Y axis, one matrix per cycle.
// Each accepted request (3x3 of signed Q16.16 entries, a 12-bit binary angle and
// an axis bit) gives one response: the request is registered together with sine
// and cosine read from the two ports of a quarter-wave table RAM, and the twelve
// multiplies, sums, floor shift by 14 and saturation land in the response
// register. Requests are taken every cycle while responses drain; rsp_ready low
// holds the pipe. After reset the table RAM is loaded by a sweep of
// 2^(ANGLE_BITS-2)+1 entries, during which req_ready is low.
module matrix_axis_rotation import mar_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int QUAD_BITS = ANGLE_BITS - 2;
   localparam int DEPTH     = (1 << QUAD_BITS) + 1;
   localparam logic [QUAD_BITS:0] QUAD_SIZE = (QUAD_BITS + 1)'(1 << QUAD_BITS);

   // table load
   logic                      fill_wr_en;
   logic [QUAD_BITS:0]        fill_wr_addr;
   logic [TRIG_MAG_WIDTH-1:0] fill_wr_data;
   logic                      fill_done;

   mar_table_fill #(
      .QUAD_BITS (QUAD_BITS)
   ) u_fill (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fill_wr_en),
      .wr_addr (fill_wr_addr),
      .wr_data (fill_wr_data),
      .done    (fill_done)
   );

   // handshake
   logic s1_valid_ff, rsp_valid_ff;
   logic rsp_adv, s1_adv, req_acc;

   assign rsp_adv   = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = !s1_valid_ff || rsp_adv;
   assign req_ready = fill_done && s1_adv;
   assign req_acc   = req_valid && req_ready;

   // table addresses for sine and cosine (cosine is a quarter turn on)
   logic [ANGLE_BITS-1:0] ang_s, ang_c;
   logic [1:0]            quad_s, quad_c;
   logic [QUAD_BITS:0]    addr_s, addr_c;

   assign ang_s  = ANGLE_BITS'(req_payload.angle);
   assign ang_c  = ang_s + ANGLE_BITS'(QUAD_SIZE);
   assign quad_s = ang_s[ANGLE_BITS-1:ANGLE_BITS-2];
   assign quad_c = ang_c[ANGLE_BITS-1:ANGLE_BITS-2];
   assign addr_s = quad_s[0] ? (QUAD_SIZE - {1'b0, ang_s[QUAD_BITS-1:0]})
                             : {1'b0, ang_s[QUAD_BITS-1:0]};
   assign addr_c = quad_c[0] ? (QUAD_SIZE - {1'b0, ang_c[QUAD_BITS-1:0]})
                             : {1'b0, ang_c[QUAD_BITS-1:0]};

   logic [TRIG_MAG_WIDTH-1:0] mag_s, mag_c;

   mar_ram #(
      .WIDTH (TRIG_MAG_WIDTH),
      .DEPTH (DEPTH)
   ) u_sine_ram (
      .clock     (clock),
      .wr_en     (fill_wr_en),
      .wr_addr   (fill_wr_addr),
      .wr_data   (fill_wr_data),
      .rd_en     (req_acc),
      .rd_addr_a (addr_s),
      .rd_addr_b (addr_c),
      .rd_data_a (mag_s),
      .rd_data_b (mag_c)
   );

   // input register stage
   req_payload_type s1_req_ff;
   logic            s_neg_ff, c_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= req_acc;
      end
      if (req_acc) begin
         s1_req_ff <= req_payload;
         // about Y the sine enters with the opposite sign
         s_neg_ff  <= quad_s[1] ^ (req_payload.action == AXIS_Y);
         c_neg_ff  <= quad_c[1];
      end
   end

   logic signed [TRIG_WIDTH-1:0] sin_val, cos_val;
   logic                         about_y;

   assign sin_val = s_neg_ff ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
   assign cos_val = c_neg_ff ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
   assign about_y = (s1_req_ff.action == AXIS_Y);

   logic signed [ENTRY_WIDTH-1:0] p0, p1, p2, a0, a1, a2, b0, b1, b2;

   assign p0 = about_y ? s1_req_ff.in_c0_r0 : s1_req_ff.in_c0_r1;
   assign p1 = about_y ? s1_req_ff.in_c1_r0 : s1_req_ff.in_c1_r1;
   assign p2 = about_y ? s1_req_ff.in_c2_r0 : s1_req_ff.in_c2_r1;

   mar_lane u_lane0 (.p(p0), .q(s1_req_ff.in_c0_r2), .cos_val(cos_val), .sin_val(sin_val),
                     .out_a(a0), .out_b(b0));
   mar_lane u_lane1 (.p(p1), .q(s1_req_ff.in_c1_r2), .cos_val(cos_val), .sin_val(sin_val),
                     .out_a(a1), .out_b(b1));
   mar_lane u_lane2 (.p(p2), .q(s1_req_ff.in_c2_r2), .cos_val(cos_val), .sin_val(sin_val),
                     .out_a(a2), .out_b(b2));

   rsp_payload_type rsp_in;

   always_comb begin
      rsp_in.out_c0_r2 = b0;
      rsp_in.out_c1_r2 = b1;
      rsp_in.out_c2_r2 = b2;
      if (about_y) begin
         rsp_in.out_c0_r0 = a0;
         rsp_in.out_c1_r0 = a1;
         rsp_in.out_c2_r0 = a2;
         rsp_in.out_c0_r1 = s1_req_ff.in_c0_r1;
         rsp_in.out_c1_r1 = s1_req_ff.in_c1_r1;
         rsp_in.out_c2_r1 = s1_req_ff.in_c2_r1;
      end else begin
         rsp_in.out_c0_r0 = s1_req_ff.in_c0_r0;
         rsp_in.out_c1_r0 = s1_req_ff.in_c1_r0;
         rsp_in.out_c2_r0 = s1_req_ff.in_c2_r0;
         rsp_in.out_c0_r1 = a0;
         rsp_in.out_c1_r1 = a1;
         rsp_in.out_c2_r1 = a2;
      end
   end

   // response register
   rsp_payload_type rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (rsp_adv && s1_valid_ff) begin
         rsp_payload_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_no_req_while_filling: assert property (@(posedge clock) disable iff (reset)
      !fill_done |-> !req_ready)
      else $error("request taken before table load finished");

   a_accept_reaches_stage: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> s1_valid_ff)
      else $error("accepted request lost at input stage");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_adv) |=> (s1_valid_ff && $stable(s1_req_ff)))
      else $error("input stage changed while stalled");

   a_stage_moves_on: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_adv) |=> rsp_valid_ff)
      else $error("request dropped between stages");

   a_x_keeps_row0: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_adv && !about_y) |=>
         (rsp_payload_ff.out_c1_r0 == $past(s1_req_ff.in_c1_r0)))
      else $error("row 0 not kept on rotation about X");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the X/Y axis rotation block: directed edges, then random traffic.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mar_pkg::*;

   localparam int QUARTER = 1 << (ANGLE_BITS_DEFAULT - 2);
   localparam int N_DIRECTED = 22;
   localparam int N_RANDOM = 750;
   localparam logic [ENTRY_WIDTH-1:0] ENTRY_MAX = {1'b0, {(ENTRY_WIDTH-1){1'b1}}};
   localparam logic [ENTRY_WIDTH-1:0] ENTRY_MIN = {1'b1, {(ENTRY_WIDTH-1){1'b0}}};

   // nine entries, c0_r0 in the top slot, as they sit in both payloads
   typedef logic [8:0][ENTRY_WIDTH-1:0] entry_grid_type;

   class rotation_scoreboard;
      int quarter_sine[QUARTER+1];
      rsp_payload_type expected_rotations[$];
      int failures;
      int noted;
      int checked;

      function bit [63:0] q60_mul(bit [63:0] a, bit [63:0] b);
         bit [63:0] ah, al, bh, bl;
         ah = a >> 32;
         al = a & 64'hFFFF_FFFF;
         bh = b >> 32;
         bl = b & 64'hFFFF_FFFF;
         return ((ah * bh) << 4) + ((ah * bl + al * bh) >> 28) + ((al * bl) >> 60);
      endfunction

      // Taylor series, x in [0, pi/2] as Q.60
      function bit [63:0] q60_sin(bit [63:0] x);
         bit [63:0] x2, term, sum, div;
         x2 = q60_mul(x, x);
         term = x;
         sum = x;
         for (int i = 1; i <= 13; i++) begin
            div = 64'(2 * i * (2 * i + 1));
            term = q60_mul(term, x2) / div;
            if (i % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         return sum;
      endfunction

      function new();
         bit [63:0] x, s;
         for (int k = 0; k <= QUARTER; k++) begin
            x = q60_mul(64'h1921FB54442D1847, 64'(k) << (60 - (ANGLE_BITS_DEFAULT - 2)));
            s = q60_sin(x);
            quarter_sine[k] = int'((s + (64'd1 << 45)) >> 46);
         end
         failures = 0;
         noted = 0;
         checked = 0;
      endfunction

      function longint sine_at(logic [ANGLE_BITS_DEFAULT-1:0] a);
         logic [1:0] quad;
         int r, mag;
         quad = a[ANGLE_BITS_DEFAULT-1 -: 2];
         r = int'(a[ANGLE_BITS_DEFAULT-3:0]);
         mag = quad[0] ? quarter_sine[QUARTER - r] : quarter_sine[r];
         return quad[1] ? -longint'(mag) : longint'(mag);
      endfunction

      function longint floor_sat(longint v);
         longint hi, lo, q;
         hi = (longint'(1) <<< (ENTRY_WIDTH - 1)) - 1;
         lo = -hi - 1;
         q = v >>> TRIG_FRAC;
         if (q > hi) return hi;
         if (q < lo) return lo;
         return q;
      endfunction

      function rsp_payload_type rotate_matrix(req_payload_type p);
         entry_grid_type src, dst;
         longint m[3], r[3];
         longint s, c;
         src = p[9*ENTRY_WIDTH-1:0];
         s = sine_at(p.angle);
         c = sine_at(p.angle + ANGLE_FIELD_WIDTH'(QUARTER));
         for (int col = 0; col < 3; col++) begin
            for (int row = 0; row < 3; row++) m[row] = longint'($signed(src[8-3*col-row]));
            if (p.action == AXIS_X) begin
               r[0] = m[0];
               r[1] = floor_sat(c * m[1] - s * m[2]);
               r[2] = floor_sat(s * m[1] + c * m[2]);
            end else begin
               r[0] = floor_sat(c * m[0] + s * m[2]);
               r[1] = m[1];
               r[2] = floor_sat(c * m[2] - s * m[0]);
            end
            for (int row = 0; row < 3; row++) dst[8-3*col-row] = r[row][ENTRY_WIDTH-1:0];
         end
         return rsp_payload_type'(dst);
      endfunction

      function void note_request(req_payload_type p);
         expected_rotations.push_back(rotate_matrix(p));
         noted++;
      endfunction

      function void check_response(rsp_payload_type got);
         entry_grid_type e, a;
         if (expected_rotations.size() == 0) begin
            $error("response with no request outstanding: %h", got);
            failures++;
            return;
         end
         e = expected_rotations.pop_front();
         a = got;
         checked++;
         for (int i = 0; i < 9; i++) begin
            if (e[8-i] !== a[8-i]) begin
               $error("out_c%0d_r%0d expected %0d got %0d", i / 3, i % 3,
                      $signed(e[8-i]), $signed(a[8-i]));
               failures++;
            end
         end
      endfunction
   endclass

   logic            clock;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   rotation_scoreboard sb = new();

   matrix_axis_rotation u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_top: errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_payload);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_payload);
      end
   end

   // idle cycles before the next handshake, with occasional runs of none
   function automatic int draw_gap(ref int run_left);
      if (run_left == 0 && $urandom_range(0, 19) == 0) run_left = $urandom_range(20, 60);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   function automatic logic [ENTRY_WIDTH-1:0] pick_entry();
      int k;
      k = $urandom_range(0, 9);
      if (k < 4) return ENTRY_WIDTH'($urandom);
      if (k < 8) return ENTRY_WIDTH'(int'($urandom_range(0, 524288)) - 262144);
      return (k == 8) ? ENTRY_MAX : ENTRY_MIN;
   endfunction

   function automatic entry_grid_type fill_pattern(int pat);
      entry_grid_type g;
      for (int i = 0; i < 9; i++) begin
         case (pat)
            0: g[8-i] = ENTRY_MAX;
            1: g[8-i] = ENTRY_MIN;
            2: g[8-i] = (i % 2 == 0) ? ENTRY_MAX : ENTRY_MIN;
            3: g[8-i] = (i % 4 == 0) ? ENTRY_WIDTH'(65536) : '0;
            default: g[8-i] = (i % 3 == 1) ? ENTRY_MAX : ENTRY_MIN;
         endcase
      end
      return g;
   endfunction

   function automatic req_payload_type make_request(logic act,
                                                    logic [ANGLE_FIELD_WIDTH-1:0] ang,
                                                    entry_grid_type g);
      return req_payload_type'({act, ang, g});
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input req_payload_type p, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic take_response(input int gap);
      if (gap > 0) begin
         rsp_ready <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      rsp_ready <= 1'b1;
      do @(posedge clock); while (!rsp_valid);
      @(negedge clock);
   endtask

   initial begin
      int run_left;
      int gap;
      int taken;
      run_left = 0;
      taken = 0;
      wait (!reset);
      @(negedge clock);
      forever begin
         gap = draw_gap(run_left);
         // long stall so the pipe fills and pushes back on requests
         if (taken == 150) gap = 400;
         take_response(gap);
         taken++;
      end
   end

   initial begin
      int dir_angles[11];
      int run_left;
      logic [ANGLE_FIELD_WIDTH-1:0] ang;
      entry_grid_type g;
      dir_angles = '{0, 1, 511, 512, 1023, 1024, 1025, 2048, 3072, 3073, 4095};
      run_left = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // quadrant edges, both axes, extreme and saturating matrices
      for (int d = 0; d < N_DIRECTED; d++) begin
         send_request(make_request(logic'(d >= 11), ANGLE_FIELD_WIDTH'(dir_angles[d % 11]),
                                   fill_pattern(d % 5)), draw_gap(run_left));
      end

      for (int n = 0; n < N_RANDOM; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            ang = ANGLE_FIELD_WIDTH'($urandom_range(0, 3) * QUARTER + $urandom_range(0, 2) - 1);
         end else begin
            ang = ANGLE_FIELD_WIDTH'($urandom_range(0, 4095));
         end
         for (int i = 0; i < 9; i++) g[i] = pick_entry();
         send_request(make_request(logic'($urandom_range(0, 1)), ang, g), draw_gap(run_left));
      end
      req_valid <= 1'b0;

      while (sb.expected_rotations.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("summary: %0d requests, %0d responses checked; both axes, quadrant edges,",
               sb.noted, sb.checked);
      $display("summary: saturation, back-pressure and bursts without gaps");
      if (sb.failures == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
